// ===== rtl/core/mfde_pkg.sv =====
// mfde_pkg: shared types, opcodes and defaults for the monochrome frame buffer draw engine.
// No dependencies; every other file in rtl/core except mfde_ram refers to it by scoped names.
package mfde_pkg;

  // default screen geometry
  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int STORE_BYTES_DEF   = 1024;

  // pixel byte index width (255 * 32 + 31 fits)
  localparam int IDX_W   = 14;
  // midpoint circle decision variable width
  localparam int DELTA_W = 20;
  // divider numerator width (magnitude of offset * minor delta)
  localparam int DIV_W   = 16;

  // command opcodes
  localparam logic [2:0] OP_PIXEL  = 3'd0;
  localparam logic [2:0] OP_LINE   = 3'd1;
  localparam logic [2:0] OP_RECT   = 3'd2;
  localparam logic [2:0] OP_FILL   = 3'd3;
  localparam logic [2:0] OP_DISC   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;
  localparam logic [2:0] OP_READ   = 3'd6;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] x_a;
    logic [7:0] y_a;
    logic [7:0] x_b;
    logic [7:0] y_b;
    logic [7:0] radius;
    logic [9:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       was_read;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic clr_step;
    logic rd_addr;
    logic rd_capture;
    logic px_read;
    logic px_write;
    logic ln_load;
    logic ln_setup;
    logic ln_mul;
    logic div_start;
    logic ln_point;
    logic ln_step;
    logic edge_next;
    logic row_init;
    logic row_next;
    logic dc_init;
    logic dc_point;
    logic dc_oct_next;
    logic dc_step;
    logic push;
  } mfde_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       clr_last;
    logic       hit;
    logic       prod_zero;
    logic       div_busy;
    logic       ln_end;
    logic       edge_last;
    logic       fill_ok;
    logic       rows_ok;
    logic       filling;
    logic       row_last;
    logic       r_zero;
    logic       oct_last;
    logic       dc_cont;
    logic       out_free;
    logic [2:0] opcode;
  } mfde_sts_t;

endpackage

// ===== rtl/core/mono_framebuffer_draw_engine.sv =====
// A clear command and the reset sweep both write zero to every byte of the frame store.
// Throughput: one command at a time, set by the read-modify-write of the
// frame store and the bit-serial divider; the result waits in an output register.
// Reset: synchronous, active low; afterwards the store is zeroed with in_stall high.
module mono_framebuffer_draw_engine #(
  parameter int SCREEN_WIDTH  = mfde_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mfde_pkg::SCREEN_HEIGHT_DEF,
  parameter int STORE_BYTES   = mfde_pkg::STORE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mfde_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mfde_pkg::out_item_t out_item
);

  mfde_pkg::mfde_cmd_t cmd;
  mfde_pkg::mfde_sts_t sts;

  mfde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfde_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .STORE_BYTES   (STORE_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

  // an accepted item keeps the engine busy in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("engine took a second item straight away");

  // divider is never restarted mid-division
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider restarted while busy");

  // clear sweep and pixel write never share the write port
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_step && cmd.px_write))
    else $error("write port conflict");

  // a result is only pushed into a free output register
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> sts.out_free)
    else $error("result overwrote a pending item");

endmodule

// ===== rtl/core/mfde_ram.sv =====
// mfde_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module mfde_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mfde_div.sv =====
// mfde_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on mfde_pkg for the numerator width.
module mfde_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mfde_pkg::DIV_W-1:0] numer,
  input  logic [7:0]                denom,
  output logic                      busy,
  output logic [mfde_pkg::DIV_W-1:0] quot
);

  localparam int CW = $clog2(mfde_pkg::DIV_W);

  logic                       busy_r, busy_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [mfde_pkg::DIV_W-1:0] num_r, num_nxt;
  logic [7:0]                 rem_r, rem_nxt;
  logic [7:0]                 den_r, den_nxt;
  logic [8:0]                 trial;
  logic                       take;

  // operand load on start, otherwise one shift-subtract step while busy
  always_comb begin
    trial    = {rem_r, num_r[mfde_pkg::DIV_W-1]};
    take     = (trial >= {1'b0, den_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = numer;
      rem_nxt  = '0;
      den_nxt  = denom;
    end else if (busy_r) begin
      rem_nxt = take ? 8'(trial - {1'b0, den_r}) : trial[7:0];
      num_nxt = {num_r[mfde_pkg::DIV_W-2:0], take};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(mfde_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign quot = num_r;

endmodule

// ===== rtl/core/mfde_datapath.sv =====
// mfde_datapath: item registers, line/rectangle/disc arithmetic, pixel read-modify-write,
// frame store and result register. Depends on mfde_pkg, mfde_ram and mfde_div.
module mfde_datapath #(
  parameter int SCREEN_WIDTH  = mfde_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mfde_pkg::SCREEN_HEIGHT_DEF,
  parameter int STORE_BYTES   = mfde_pkg::STORE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mfde_pkg::in_item_t  in_item,
  input  logic                out_stall,
  output logic                out_valid,
  output mfde_pkg::out_item_t out_item,
  input  mfde_pkg::mfde_cmd_t cmd,
  output mfde_pkg::mfde_sts_t sts
);

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int BPC = SCREEN_HEIGHT / 8;
  localparam int IW  = mfde_pkg::IDX_W;
  localparam int DW  = mfde_pkg::DELTA_W;
  localparam int NW  = mfde_pkg::DIV_W;

  // item registers
  logic [2:0] op_r;
  logic [7:0] xa_r, ya_r, xb_r, yb_r, rad_r;
  logic [9:0] ridx_r;

  // clear sweep counter
  logic [AW-1:0] clr_cnt_r;

  // pixel under work
  logic [7:0] px_r, py_r;

  // line state
  logic [7:0]        lx1_r, ly1_r, lx2_r, ly2_r;
  logic              xmaj_r, up_r;
  logic [7:0]        a_r, b_r, st_r, mn_r;
  logic signed [7:0] dmaj_r, dmin_r;
  logic signed [16:0] prod_r;

  // rectangle state
  logic [1:0] edge_r;
  logic       fill_r;
  logic [7:0] row_r;

  // disc state
  logic [7:0]          cx_r, cy_r;
  logic signed [DW-1:0] dlt_r;
  logic [2:0]          oct_r;

  // result
  logic [7:0]          res_data_r;
  logic                res_read_r;
  logic                out_valid_r;
  mfde_pkg::out_item_t out_item_r;

  // memory and divider
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [7:0]    wdata, rdata;
  logic          div_busy;
  logic [NW-1:0] div_quot, div_num;
  logic [7:0]    div_den;

  // pixel address and clipping
  logic [IW-1:0] pix_idx, ridx_ext;
  logic          hit, rd_ok;

  assign pix_idx  = IW'(px_r) * IW'(BPC) + IW'(py_r[7:3]);
  assign ridx_ext = IW'(ridx_r);
  assign hit      = ({1'b0, px_r} < 9'(SCREEN_WIDTH)) && ({1'b0, py_r} < 9'(SCREEN_HEIGHT))
                 && (pix_idx < IW'(STORE_BYTES));
  assign rd_ok    = (ridx_ext < IW'(STORE_BYTES));

  // frame store ports
  assign raddr = cmd.rd_addr ? ridx_ext[AW-1:0] : pix_idx[AW-1:0];
  assign we    = cmd.clr_step | cmd.px_write;
  assign waddr = cmd.clr_step ? clr_cnt_r : pix_idx[AW-1:0];
  assign wdata = cmd.clr_step ? 8'h00 : (rdata | (8'h01 << py_r[2:0]));

  mfde_ram #(
    .DATA_W (8),
    .DEPTH  (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // rectangle inner spans
  logic [7:0] xmin, xmax, ymin, ymax, xlo, xhi, ylo, yhi;

  always_comb begin
    xmin = (xa_r < xb_r) ? xa_r : xb_r;
    xmax = (xa_r < xb_r) ? xb_r : xa_r;
    ymin = (ya_r < yb_r) ? ya_r : yb_r;
    ymax = (ya_r < yb_r) ? yb_r : ya_r;
    xlo  = xmin + 8'd1;
    xhi  = xmax - 8'd1;
    ylo  = ymin + 8'd1;
    yhi  = ymax - 8'd1;
  end

  // line endpoint selection
  logic [7:0] ld_x1, ld_y1, ld_x2, ld_y2;

  always_comb begin
    ld_x1 = xa_r;
    ld_y1 = ya_r;
    ld_x2 = xb_r;
    ld_y2 = yb_r;
    if (op_r != mfde_pkg::OP_LINE) begin
      if (fill_r) begin
        ld_x1 = xlo;
        ld_y1 = row_r;
        ld_x2 = xhi;
        ld_y2 = row_r;
      end else begin
        case (edge_r)
          2'd0: begin
            ld_x1 = xa_r; ld_y1 = ya_r; ld_x2 = xa_r; ld_y2 = yb_r;
          end
          2'd1: begin
            ld_x1 = xb_r; ld_y1 = ya_r; ld_x2 = xb_r; ld_y2 = yb_r;
          end
          2'd2: begin
            ld_x1 = xa_r; ld_y1 = ya_r; ld_x2 = xb_r; ld_y2 = ya_r;
          end
          default: begin
            ld_x1 = xa_r; ld_y1 = yb_r; ld_x2 = xb_r; ld_y2 = yb_r;
          end
        endcase
      end
    end
  end

  // line setup: deltas and major axis
  logic signed [7:0] ldx, ldy;
  logic [7:0]        adx, ady;
  logic              lxmaj;

  always_comb begin
    ldx   = signed'(lx2_r - lx1_r);
    ldy   = signed'(ly2_r - ly1_r);
    adx   = ldx[7] ? 8'(-ldx) : 8'(ldx);
    ady   = ldy[7] ? 8'(-ldy) : 8'(ldy);
    lxmaj = (adx > ady);
  end

  // offset along the major axis times minor delta
  logic signed [8:0]  off;
  logic signed [16:0] prod;
  logic               prod_zero;

  assign off       = signed'({1'b0, a_r}) - signed'({1'b0, st_r});
  assign prod      = off * dmin_r;
  assign prod_zero = (prod_r == '0);
  assign div_num   = prod_r[16] ? NW'(-prod_r) : NW'(prod_r);
  assign div_den   = dmaj_r[7] ? 8'(-dmaj_r) : 8'(dmaj_r);

  mfde_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .numer (div_num),
    .denom (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // minor coordinate: signed quotient, truncated toward zero, plus start
  logic [7:0] q8, qs, minor;

  always_comb begin
    q8    = div_quot[7:0];
    qs    = prod_zero ? 8'd0 : ((prod_r[16] ^ dmaj_r[7]) ? 8'(-q8) : q8);
    minor = mn_r + qs;
  end

  // disc octant point
  logic [7:0] dc_px, dc_py;

  always_comb begin
    case (oct_r)
      3'd0: begin dc_px = cx_r + a_r; dc_py = cy_r + b_r; end
      3'd1: begin dc_px = cx_r + a_r; dc_py = cy_r - b_r; end
      3'd2: begin dc_px = cx_r - a_r; dc_py = cy_r + b_r; end
      3'd3: begin dc_px = cx_r - a_r; dc_py = cy_r - b_r; end
      3'd4: begin dc_px = cx_r + b_r; dc_py = cy_r + a_r; end
      3'd5: begin dc_px = cx_r + b_r; dc_py = cy_r - a_r; end
      3'd6: begin dc_px = cx_r - b_r; dc_py = cy_r + a_r; end
      default: begin dc_px = cx_r - b_r; dc_py = cy_r - a_r; end
    endcase
  end

  // midpoint circle step; a_r holds x and b_r holds y during a disc
  logic signed [DW-1:0] ix, iy, err, ix1, iy1, dlt1;
  logic [7:0]           dcx1, dcy1;

  always_comb begin
    ix   = DW'(a_r);
    iy   = DW'(b_r);
    err  = ((dlt_r + iy) <<< 1) - DW'(1);
    dcx1 = a_r;
    dcy1 = b_r;
    if (dlt_r < 0 && err <= 0) begin
      dcx1 = a_r + 8'd1;
    end else if (dlt_r > 0 && err > 0) begin
      dcy1 = b_r - 8'd1;
    end else begin
      dcx1 = a_r + 8'd1;
      dcy1 = b_r - 8'd1;
    end
    ix1 = DW'(dcx1);
    iy1 = DW'(dcy1);
    if (dlt_r < 0 && err <= 0) begin
      dlt1 = dlt_r + (ix1 <<< 1) + DW'(1);
    end else if (dlt_r > 0 && err > 0) begin
      dlt1 = dlt_r - ((iy1 <<< 1) + DW'(1));
    end else begin
      dlt1 = dlt_r + ((ix1 - iy1) <<< 1);
    end
  end

  // control-state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    // item capture
    if (cmd.load_item) begin
      op_r       <= in_item.opcode;
      xa_r       <= in_item.x_a;
      ya_r       <= in_item.y_a;
      xb_r       <= in_item.x_b;
      yb_r       <= in_item.y_b;
      rad_r      <= in_item.radius;
      ridx_r     <= in_item.read_index;
      px_r       <= in_item.x_a;
      py_r       <= in_item.y_a;
      cx_r       <= in_item.x_a;
      cy_r       <= in_item.y_a;
      res_data_r <= 8'd0;
      res_read_r <= (in_item.opcode == mfde_pkg::OP_READ);
      edge_r     <= 2'd0;
      fill_r     <= 1'b0;
    end
    if (cmd.rd_capture) begin
      res_data_r <= rd_ok ? rdata : 8'd0;
    end
    // rectangle sequencing
    if (cmd.edge_next) begin
      edge_r <= edge_r + 2'd1;
    end
    if (cmd.row_init) begin
      fill_r <= 1'b1;
      row_r  <= ylo;
    end else if (cmd.row_next) begin
      row_r <= row_r + 8'd1;
    end
    // line
    if (cmd.ln_load) begin
      lx1_r <= ld_x1;
      ly1_r <= ld_y1;
      lx2_r <= ld_x2;
      ly2_r <= ld_y2;
    end
    if (cmd.ln_setup) begin
      xmaj_r <= lxmaj;
      a_r    <= lxmaj ? lx1_r : ly1_r;
      st_r   <= lxmaj ? lx1_r : ly1_r;
      b_r    <= lxmaj ? lx2_r : ly2_r;
      mn_r   <= lxmaj ? ly1_r : lx1_r;
      up_r   <= lxmaj ? (lx1_r < lx2_r) : (ly1_r < ly2_r);
      dmaj_r <= lxmaj ? ldx : ldy;
      dmin_r <= lxmaj ? ldy : ldx;
    end
    if (cmd.ln_mul) begin
      prod_r <= prod;
    end
    if (cmd.ln_point) begin
      px_r <= xmaj_r ? a_r : minor;
      py_r <= xmaj_r ? minor : a_r;
    end
    if (cmd.ln_step) begin
      a_r <= up_r ? a_r + 8'd1 : a_r - 8'd1;
    end
    // disc
    if (cmd.dc_init) begin
      a_r   <= 8'd0;
      b_r   <= rad_r;
      dlt_r <= DW'(1) - (DW'(rad_r) <<< 1);
      oct_r <= 3'd0;
    end
    if (cmd.dc_point) begin
      px_r <= dc_px;
      py_r <= dc_py;
    end
    if (cmd.dc_oct_next) begin
      oct_r <= oct_r + 3'd1;
    end
    if (cmd.dc_step) begin
      a_r   <= dcx1;
      b_r   <= dcy1;
      dlt_r <= dlt1;
      oct_r <= 3'd0;
      if (dcy1 < dcx1) begin
        rad_r <= rad_r - 8'd1;
      end
    end
    // result
    if (cmd.push) begin
      out_item_r.read_data <= res_data_r;
      out_item_r.was_read  <= res_read_r;
    end
  end

  // status to the controller
  always_comb begin
    sts.clr_last  = (clr_cnt_r == AW'(STORE_BYTES - 1));
    sts.hit       = hit;
    sts.prod_zero = prod_zero;
    sts.div_busy  = div_busy;
    sts.ln_end    = (a_r == b_r);
    sts.edge_last = (edge_r == 2'd3);
    sts.fill_ok   = (op_r == mfde_pkg::OP_FILL) && (xa_r != xb_r) && (ya_r != yb_r);
    sts.rows_ok   = (ylo <= yhi);
    sts.filling   = fill_r;
    sts.row_last  = (row_r == yhi);
    sts.r_zero    = (rad_r == 8'd0);
    sts.oct_last  = (oct_r == 3'd7);
    sts.dc_cont   = (dcy1 >= dcx1);
    sts.out_free  = !out_valid_r || !out_stall;
    sts.opcode    = op_r;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/core/mfde_ctrl.sv =====
// mfde_ctrl: command sequencer for the draw engine (clear sweep, read, pixel, line,
// rectangle and disc walks). Depends on mfde_pkg.
module mfde_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mfde_pkg::mfde_sts_t sts,
  output mfde_pkg::mfde_cmd_t cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISPATCH = 5'd1;
  localparam logic [4:0] S_CLR      = 5'd2;
  localparam logic [4:0] S_RD_ADDR  = 5'd3;
  localparam logic [4:0] S_RD_DATA  = 5'd4;
  localparam logic [4:0] S_DONE     = 5'd5;
  localparam logic [4:0] S_PX_RD    = 5'd6;
  localparam logic [4:0] S_PX_WR    = 5'd7;
  localparam logic [4:0] S_PX_NEXT  = 5'd8;
  localparam logic [4:0] S_LN_LOAD  = 5'd9;
  localparam logic [4:0] S_LN_SETUP = 5'd10;
  localparam logic [4:0] S_LN_MUL   = 5'd11;
  localparam logic [4:0] S_LN_DIV   = 5'd12;
  localparam logic [4:0] S_LN_WAIT  = 5'd13;
  localparam logic [4:0] S_LN_PT    = 5'd14;
  localparam logic [4:0] S_LN_END   = 5'd15;
  localparam logic [4:0] S_DC_INIT  = 5'd16;
  localparam logic [4:0] S_DC_PT    = 5'd17;
  localparam logic [4:0] S_DC_STEP  = 5'd18;

  logic [4:0] state_r, state_nxt;
  logic       boot_r, boot_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    boot_nxt  = boot_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.opcode)
          mfde_pkg::OP_PIXEL: state_nxt = S_PX_RD;
          mfde_pkg::OP_LINE:  state_nxt = S_LN_LOAD;
          mfde_pkg::OP_RECT:  state_nxt = S_LN_LOAD;
          mfde_pkg::OP_FILL:  state_nxt = S_LN_LOAD;
          mfde_pkg::OP_DISC:  state_nxt = S_DC_INIT;
          mfde_pkg::OP_CLEAR: state_nxt = S_CLR;
          mfde_pkg::OP_READ:  state_nxt = S_RD_ADDR;
          default:            state_nxt = S_DONE;
        endcase
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          boot_nxt  = 1'b0;
          state_nxt = boot_r ? S_IDLE : S_DONE;
        end
      end
      S_RD_ADDR: begin
        cmd.rd_addr = 1'b1;
        state_nxt   = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      // pixel read-modify-write, skipped when clipped
      S_PX_RD: begin
        if (sts.hit) begin
          cmd.px_read = 1'b1;
          state_nxt   = S_PX_WR;
        end else begin
          state_nxt = S_PX_NEXT;
        end
      end
      S_PX_WR: begin
        cmd.px_write = 1'b1;
        state_nxt    = S_PX_NEXT;
      end
      S_PX_NEXT: begin
        case (sts.opcode)
          mfde_pkg::OP_LINE, mfde_pkg::OP_RECT, mfde_pkg::OP_FILL: begin
            if (sts.ln_end) begin
              state_nxt = S_LN_END;
            end else begin
              cmd.ln_step = 1'b1;
              state_nxt   = S_LN_MUL;
            end
          end
          mfde_pkg::OP_DISC: begin
            if (sts.oct_last) begin
              state_nxt = S_DC_STEP;
            end else begin
              cmd.dc_oct_next = 1'b1;
              state_nxt       = S_DC_PT;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      // line walk
      S_LN_LOAD: begin
        cmd.ln_load = 1'b1;
        state_nxt   = S_LN_SETUP;
      end
      S_LN_SETUP: begin
        cmd.ln_setup = 1'b1;
        state_nxt    = S_LN_MUL;
      end
      S_LN_MUL: begin
        cmd.ln_mul = 1'b1;
        state_nxt  = S_LN_DIV;
      end
      S_LN_DIV: begin
        if (sts.prod_zero) begin
          state_nxt = S_LN_PT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_LN_WAIT;
        end
      end
      S_LN_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = S_LN_PT;
        end
      end
      S_LN_PT: begin
        cmd.ln_point = 1'b1;
        state_nxt    = S_PX_RD;
      end
      // line end: a line is done; otherwise rectangle edges, then fill rows
      S_LN_END: begin
        if (sts.opcode == mfde_pkg::OP_LINE) begin
          state_nxt = S_DONE;
        end else if (!sts.edge_last) begin
          cmd.edge_next = 1'b1;
          state_nxt     = S_LN_LOAD;
        end else if (!sts.filling) begin
          if (sts.fill_ok && sts.rows_ok) begin
            cmd.row_init = 1'b1;
            state_nxt    = S_LN_LOAD;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (sts.row_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.row_next = 1'b1;
          state_nxt    = S_LN_LOAD;
        end
      end
      // disc: concentric circles from the radius down
      S_DC_INIT: begin
        if (sts.r_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.dc_init = 1'b1;
          state_nxt   = S_DC_PT;
        end
      end
      S_DC_PT: begin
        cmd.dc_point = 1'b1;
        state_nxt    = S_PX_RD;
      end
      S_DC_STEP: begin
        cmd.dc_step = 1'b1;
        state_nxt   = sts.dc_cont ? S_DC_PT : S_DC_INIT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      boot_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      boot_r  <= boot_nxt;
    end
  end

endmodule
